### rtl/svm_pkg.sv
`timescale 1ns / 1ps

package svm_pkg;

   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 8;
   localparam int SUM_W    = 32;
   localparam int PROD_W   = 41;
   localparam int QUOT_W   = 18;

   // floor(m / 100) == (m * RECIP_100) >> RECIP_SHIFT for every m below 2**MAG_W
   localparam int MAG_W       = 24;
   localparam int RECIP_W     = 25;
   localparam int RECIP_SHIFT = 31;
   localparam logic [RECIP_W-1:0] RECIP_100 = 25'd21474837;

   localparam logic [QUOT_W-1:0] SAT_POS_MAG = 18'd32767;
   localparam logic [QUOT_W-1:0] SAT_NEG_MAG = 18'd32768;
   localparam logic signed [SAMPLE_W-1:0] SAT_POS = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAT_NEG = -16'sh8000;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_MASTER_VOLUME = 1'b0;
   localparam logic [GAIN_W-1:0] MASTER_VOLUME_RESET = 8'd100;

   typedef struct packed {
      logic signed [15:0] left_sample;
      logic signed [15:0] right_sample;
      logic [7:0]         voice_gain;
      logic               voice_active;
      logic               last_voice;
   } req_type;

   typedef struct packed {
      logic signed [15:0] left_mix;
      logic signed [15:0] right_mix;
      logic [31:0]        packed_frame;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic mul_master;
      logic div;
      logic acc;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic voice_active;
      logic last_voice;
      logic out_busy;
   } dp_sts_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MUL  = 7'b0000010,
      ST_DIV  = 7'b0000100,
      ST_ACC  = 7'b0001000,
      ST_MMUL = 7'b0010000,
      ST_MDIV = 7'b0100000,
      ST_FIN  = 7'b1000000
   } state_type;

endpackage

### rtl/svm_lane.sv
`timescale 1ns / 1ps

module svm_lane (
   input  logic                     clock,
   input  logic                     reset,
   input  svm_pkg::dp_cmd_type      cmd,
   input  logic signed [15:0]       sample,
   input  logic [7:0]               gain,
   input  logic [7:0]               master,
   output logic signed [15:0]       mix
);
   import svm_pkg::*;

   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [QUOT_W-1:0]        quot_ff, quot_in;
   logic                     neg_ff, neg_in;
   logic                     ovf_ff, ovf_in;

   logic signed [SUM_W-1:0]  op_a;
   logic [GAIN_W-1:0]        op_b;
   logic signed [PROD_W-1:0] a_ext, b_ext;
   logic [PROD_W-1:0]        mag;
   logic [MAG_W+RECIP_W-1:0] recip_prod;
   logic signed [SUM_W-1:0]  term;

   // shared multiplier: sample x voice gain, or sum x master volume
   always_comb begin
      op_a    = cmd.mul_master ? sum_ff : SUM_W'(sample);
      op_b    = cmd.mul_master ? master : gain;
      a_ext   = PROD_W'(op_a);
      b_ext   = $signed({{(PROD_W-GAIN_W){1'b0}}, op_b});
      prod_in = cmd.mul ? a_ext * b_ext : prod_ff;
   end

   // divide magnitude by 100, truncating toward zero
   always_comb begin
      mag        = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
      recip_prod = (MAG_W+RECIP_W)'(mag[MAG_W-1:0]) * (MAG_W+RECIP_W)'(RECIP_100);
      quot_in    = cmd.div ? recip_prod[RECIP_SHIFT +: QUOT_W] : quot_ff;
      neg_in     = cmd.div ? prod_ff[PROD_W-1] : neg_ff;
      ovf_in     = cmd.div ? |mag[PROD_W-1:MAG_W] : ovf_ff;
   end

   always_comb begin
      term = SUM_W'({{(SUM_W-QUOT_W){1'b0}}, quot_ff});
      if (cmd.emit) begin
         sum_in = '0;
      end else if (cmd.acc) begin
         sum_in = sum_ff + (neg_ff ? -term : term);
      end else begin
         sum_in = sum_ff;
      end
   end

   always_comb begin
      if (!neg_ff) begin
         mix = (ovf_ff || quot_ff > SAT_POS_MAG) ? SAT_POS : $signed(quot_ff[15:0]);
      end else begin
         mix = (ovf_ff || quot_ff > SAT_NEG_MAG) ? SAT_NEG : $signed(16'(-quot_ff[15:0]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      quot_ff <= quot_in;
      neg_ff  <= neg_in;
      ovf_ff  <= ovf_in;
   end

endmodule

### rtl/svm_dp.sv
`timescale 1ns / 1ps

module svm_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  svm_pkg::dp_cmd_type  cmd,
   output svm_pkg::dp_sts_type  sts,
   input  svm_pkg::req_type     req_data,
   input  logic [7:0]           master,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output svm_pkg::rsp_type     rsp_data
);
   import svm_pkg::*;

   req_type            item_ff, item_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] left_mix, right_mix;

   svm_lane u_left (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .sample (item_ff.left_sample),
      .gain   (item_ff.voice_gain),
      .master (master),
      .mix    (left_mix)
   );

   svm_lane u_right (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .sample (item_ff.right_sample),
      .gain   (item_ff.voice_gain),
      .master (master),
      .mix    (right_mix)
   );

   always_comb begin
      item_in = cmd.load ? req_data : item_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit) begin
         rsp_data_in.left_mix     = left_mix;
         rsp_data_in.right_mix    = right_mix;
         rsp_data_in.packed_frame = {left_mix, right_mix};
         rsp_valid_in             = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign sts.voice_active = item_ff.voice_active;
   assign sts.last_voice   = item_ff.last_voice;
   assign sts.out_busy     = rsp_valid_ff && rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;

endmodule

### rtl/svm_ctrl.sv
`timescale 1ns / 1ps

module svm_ctrl #(
   parameter int MAX_VOICES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output svm_pkg::dp_cmd_type  cmd,
   input  svm_pkg::dp_sts_type  sts
);
   import svm_pkg::*;

   localparam int CNT_W = $clog2(MAX_VOICES + 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             room;

   assign room = count_ff < CNT_W'(MAX_VOICES);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MUL;
         end
         ST_MUL:  state_in = ST_DIV;
         ST_DIV:  state_in = ST_ACC;
         ST_ACC:  state_in = sts.last_voice ? ST_MMUL : ST_IDLE;
         ST_MMUL: state_in = ST_MDIV;
         ST_MDIV: state_in = ST_FIN;
         ST_FIN: begin
            if (!sts.out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.load       = (state_ff == ST_IDLE) && req_valid;
      cmd.mul        = (state_ff == ST_MUL) || (state_ff == ST_MMUL);
      cmd.mul_master = (state_ff == ST_MMUL);
      cmd.div        = (state_ff == ST_DIV) || (state_ff == ST_MDIV);
      cmd.acc        = (state_ff == ST_ACC) && sts.voice_active && room;
      cmd.emit       = (state_ff == ST_FIN) && !sts.out_busy;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.emit) begin
         count_in = '0;
      end else if (state_ff == ST_ACC && room) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

### rtl/stereo_voice_mixer.sv
`timescale 1ns / 1ps
// Voice item: accepted in idle, then multiply, divide and accumulate states, then back to idle.
// Closing item: then master multiply, master divide and finish; the frame is registered on rsp
// from finish, which waits only while a previous frame is still stalled in the output register.
// The pace is set by the controller sequence through one multiplier and one divider per channel.
// Synchronous active-high reset clears the sums, voice count and output valid; master volume 100.

module stereo_voice_mixer #(
   parameter int MAX_VOICES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  svm_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output svm_pkg::rsp_type                    rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [svm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [svm_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [svm_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import svm_pkg::*;

   dp_cmd_type        cmd;
   dp_sts_type        sts;
   logic [GAIN_W-1:0] master_ff, master_in;
   logic              reg_hit;

   assign reg_hit    = (csr_paddr[2] == REG_MASTER_VOLUME);
   assign csr_pready = 1'b1;
   assign csr_prdata = reg_hit ? CSR_DATA_W'(master_ff) : '0;

   always_comb begin
      master_in = master_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_hit) begin
         master_in = csr_pwdata[GAIN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         master_ff <= MASTER_VOLUME_RESET;
      end else begin
         master_ff <= master_in;
      end
   end

   svm_ctrl #(
      .MAX_VOICES (MAX_VOICES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   svm_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .master    (master_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/svm_checker.sv
`timescale 1ns / 1ps

module svm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input svm_pkg::req_type                req_data,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input svm_pkg::rsp_type                rsp_data
);
   import svm_pkg::*;

   // stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

   a_packed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.packed_frame == {rsp_data.left_mix, rsp_data.right_mix})
      else $error("packed frame disagrees with fields");

   // an accepted item keeps the block busy through its multiply and divide states
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall ##1 req_stall)
      else $error("input taken again too early");

   // a frame only appears after the input side was busy, as it is while a closing item runs
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall, 1) && $past(req_stall, 6))
      else $error("result without a closing item");

endmodule

bind stereo_voice_mixer svm_checker u_svm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
